@@ rtl/erp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_pkg
// Shared types, constants and arithmetic helpers for the pivot rotation core.
// ----------------------------------------------------------------------------
package erp_pkg;

	// Field and datapath widths
	localparam int COORD_W       = 32;
	localparam int ANGLE_W       = 17;
	localparam int CIW           = COORD_W + 4;
	localparam int TRIG_W        = 32;
	localparam int CW            = 34;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_N        = 24;
	localparam int NUM_ITER      = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
	localparam int ITER_W        = $clog2(ATAN_N);
	localparam int PROD_W        = CIW + TRIG_W;
	localparam int RND_W         = PROD_W - 30 + 1;
	localparam int MAG_W         = 14;
	localparam int RAD_C_W       = 28;
	localparam int RAD_P_W       = MAG_W + RAD_C_W;
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 32;
	localparam int NUM_AXES      = 3;

	// Angle handling constants
	localparam logic [RAD_C_W-1:0] DEG100_TO_RAD_Q40 = 28'd191900981;
	localparam logic signed [CW-1:0] INV_GAIN_Q30    = 34'sd652032874;

	// Register indexes
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_ANG_X = 3'd0;
	localparam reg_idx_t REG_ANG_Y = 3'd1;
	localparam reg_idx_t REG_ANG_Z = 3'd2;
	localparam reg_idx_t REG_PIV_X = 3'd3;
	localparam reg_idx_t REG_PIV_Y = 3'd4;
	localparam reg_idx_t REG_PIV_Z = 3'd5;

	// Sine and cosine of one axis angle, Q30
	typedef struct packed {
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [TRIG_W-1:0] cos_v;
	} trig_t;

	// Truncated arctangent table, Q30
	function automatic logic signed [CW-1:0] atan_q30(input logic [ITER_W-1:0] i);
		logic signed [CW-1:0] r;
		case (i)
			5'd0:    r = 34'sd843314856;
			5'd1:    r = 34'sd497837829;
			5'd2:    r = 34'sd263043836;
			5'd3:    r = 34'sd133525158;
			5'd4:    r = 34'sd67021686;
			5'd5:    r = 34'sd33543515;
			5'd6:    r = 34'sd16775850;
			5'd7:    r = 34'sd8388437;
			5'd8:    r = 34'sd4194282;
			5'd9:    r = 34'sd2097149;
			5'd10:   r = 34'sd1048575;
			5'd11:   r = 34'sd524287;
			5'd12:   r = 34'sd262143;
			5'd13:   r = 34'sd131071;
			5'd14:   r = 34'sd65535;
			5'd15:   r = 34'sd32767;
			5'd16:   r = 34'sd16383;
			5'd17:   r = 34'sd8191;
			5'd18:   r = 34'sd4095;
			5'd19:   r = 34'sd2047;
			5'd20:   r = 34'sd1023;
			5'd21:   r = 34'sd511;
			5'd22:   r = 34'sd255;
			5'd23:   r = 34'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Scale a Q30 product back down, rounding half away from zero
	function automatic logic signed [RND_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] sum;
		logic [RND_W-1:0]  r;
		mag = p[PROD_W-1] ? (~p + 1'b1) : p;
		sum = mag + (PROD_W'(1) << 29);
		r   = {1'b0, sum[PROD_W-1:30]};
		return p[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

endpackage

@@ rtl/erp_point_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_point_if
// Input channel: one 3D point word per valid/ready handshake.
// ----------------------------------------------------------------------------
interface erp_point_if;
	import erp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;

	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

@@ rtl/erp_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_result_if
// Output channel: one rotated point word per valid/ready handshake.
// ----------------------------------------------------------------------------
interface erp_result_if;
	import erp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] rotated_x;
	logic signed [COORD_W-1:0] rotated_y;
	logic signed [COORD_W-1:0] rotated_z;
	logic                      saturated;

	modport source (output valid, rotated_x, rotated_y, rotated_z, saturated, input ready);
	modport sink   (input valid, rotated_x, rotated_y, rotated_z, saturated, output ready);
endinterface

@@ rtl/euler_rotate_point_about_pivot_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_rotate_point_about_pivot_core
// Rotates a Q16.16 point about a pivot by X, then Y, then Z Euler angles.
// ----------------------------------------------------------------------------
// Usage: the core takes one point word per cycle while point.ready is high
// and passes it through eight register stages: pivot subtract, two per axis
// rotation, clamp and output register. Result-side stalls back up stage by
// stage and lose nothing. Sine and cosine are held per axis and come from a
// shared iterative CORDIC that reduces, converts, iterates and stores each
// axis in turn. It runs after reset and after every angle register write,
// and point.ready stays low for that time. Pivot writes take effect at once.
// Registers sit at byte addresses 0x00..0x14 (angle X, Y, Z, pivot X, Y, Z);
// write them only while no point is in flight.
// ----------------------------------------------------------------------------
module euler_rotate_point_about_pivot_core (
	input  logic                          clk,
	input  logic                          arst_n,
	erp_point_if.sink                     point,
	erp_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [erp_pkg::ADDR_W-1:0]    paddr,
	input  logic [erp_pkg::DATA_W-1:0]    pwdata,
	output logic [erp_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import erp_pkg::*;

	localparam int NUM_ST = 8;

	// Configuration registers
	logic signed [ANGLE_W-1:0] ang_q [NUM_AXES];
	logic signed [COORD_W-1:0] piv_q [NUM_AXES];
	logic                      wr;
	logic                      restart;
	reg_idx_t                  idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[4:2];

	// Decode register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				ang_q[i] <= '0;
				piv_q[i] <= '0;
			end
		end else if (wr) begin
			unique case (idx)
				REG_ANG_X: ang_q[0] <= pwdata[ANGLE_W-1:0];
				REG_ANG_Y: ang_q[1] <= pwdata[ANGLE_W-1:0];
				REG_ANG_Z: ang_q[2] <= pwdata[ANGLE_W-1:0];
				REG_PIV_X: piv_q[0] <= pwdata[COORD_W-1:0];
				REG_PIV_Y: piv_q[1] <= pwdata[COORD_W-1:0];
				REG_PIV_Z: piv_q[2] <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Flag an angle change to the trig unit
	always_comb begin
		restart = 1'b0;
		if (wr) begin
			case (idx)
				REG_ANG_X, REG_ANG_Y, REG_ANG_Z: restart = 1'b1;
				default: restart = 1'b0;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			REG_ANG_X: prdata = DATA_W'(ang_q[0]);
			REG_ANG_Y: prdata = DATA_W'(ang_q[1]);
			REG_ANG_Z: prdata = DATA_W'(ang_q[2]);
			REG_PIV_X: prdata = DATA_W'(piv_q[0]);
			REG_PIV_Y: prdata = DATA_W'(piv_q[1]);
			REG_PIV_Z: prdata = DATA_W'(piv_q[2]);
			default:   prdata = '0;
		endcase
	end

	// Trig unit
	trig_t trig [NUM_AXES];
	logic  trig_busy;

	erp_trig u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.angle   (ang_q),
		.restart (restart),
		.trig    (trig),
		.busy    (trig_busy)
	);

	// Stage enables: a stage loads when empty or when the next one loads
	logic [NUM_ST:1] vld_q;
	logic [NUM_ST:1] adv;
	logic            in_acc;

	always_comb begin
		adv[NUM_ST] = !vld_q[NUM_ST] || result.ready;
		for (int k = NUM_ST - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign point.ready = adv[1] && !trig_busy;
	assign in_acc      = point.valid && point.ready;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_acc;
			end
			for (int k = 2; k <= NUM_ST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: move the pivot to the origin
	logic signed [CIW-1:0] m_s1, n_s1, o_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			m_s1 <= CIW'(point.point_x) - CIW'(piv_q[0]);
			n_s1 <= CIW'(point.point_y) - CIW'(piv_q[1]);
			o_s1 <= CIW'(point.point_z) - CIW'(piv_q[2]);
		end
	end

	// Stages 2-3: rotate about X (y, z plane)
	logic signed [CIW-1:0] m_s2, m_s3, n_s3, o_s3;

	erp_rot u_rot_x (
		.clk   (clk),
		.en_p  (adv[2]),
		.en_q  (adv[3]),
		.u     (n_s1),
		.w     (o_s1),
		.sc    (trig[0]),
		.u_new (n_s3),
		.w_new (o_s3)
	);

	always_ff @(posedge clk) begin
		if (adv[2]) m_s2 <= m_s1;
		if (adv[3]) m_s3 <= m_s2;
	end

	// Stages 4-5: rotate about Y (z, x plane)
	logic signed [CIW-1:0] n_s4, n_s5, m_s5, o_s5;

	erp_rot u_rot_y (
		.clk   (clk),
		.en_p  (adv[4]),
		.en_q  (adv[5]),
		.u     (o_s3),
		.w     (m_s3),
		.sc    (trig[1]),
		.u_new (o_s5),
		.w_new (m_s5)
	);

	always_ff @(posedge clk) begin
		if (adv[4]) n_s4 <= n_s3;
		if (adv[5]) n_s5 <= n_s4;
	end

	// Stages 6-7: rotate about Z (x, y plane)
	logic signed [CIW-1:0] o_s6, o_s7, m_s7, n_s7;

	erp_rot u_rot_z (
		.clk   (clk),
		.en_p  (adv[6]),
		.en_q  (adv[7]),
		.u     (m_s5),
		.w     (n_s5),
		.sc    (trig[2]),
		.u_new (m_s7),
		.w_new (n_s7)
	);

	always_ff @(posedge clk) begin
		if (adv[6]) o_s6 <= o_s5;
		if (adv[7]) o_s7 <= o_s6;
	end

	// Stage 8: restore the pivot and clamp to the coordinate range
	localparam logic signed [CIW:0] HI = {{(CIW-COORD_W+2){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [CIW:0] LO = ~HI;

	logic signed [CIW:0]       sum [NUM_AXES];
	logic signed [COORD_W-1:0] clp [NUM_AXES];
	logic [NUM_AXES-1:0]       sat;
	logic signed [COORD_W-1:0] rx_s8, ry_s8, rz_s8;
	logic                      sat_s8;

	always_comb begin
		sum[0] = (CIW+1)'(m_s7) + (CIW+1)'(piv_q[0]);
		sum[1] = (CIW+1)'(n_s7) + (CIW+1)'(piv_q[1]);
		sum[2] = (CIW+1)'(o_s7) + (CIW+1)'(piv_q[2]);
		for (int i = 0; i < NUM_AXES; i++) begin
			sat[i] = 1'b1;
			if (sum[i] > HI) begin
				clp[i] = HI[COORD_W-1:0];
			end else if (sum[i] < LO) begin
				clp[i] = LO[COORD_W-1:0];
			end else begin
				clp[i] = sum[i][COORD_W-1:0];
				sat[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			rx_s8  <= clp[0];
			ry_s8  <= clp[1];
			rz_s8  <= clp[2];
			sat_s8 <= |sat;
		end
	end

	assign result.valid     = vld_q[NUM_ST];
	assign result.rotated_x = rx_s8;
	assign result.rotated_y = ry_s8;
	assign result.rotated_z = rz_s8;
	assign result.saturated = sat_s8;

endmodule

@@ rtl/erp_trig.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_trig
// Sequential CORDIC that turns the three axis angles into sine and cosine.
// Runs one axis after another whenever an angle changes and after reset.
// ----------------------------------------------------------------------------
module erp_trig (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [erp_pkg::ANGLE_W-1:0]  angle [erp_pkg::NUM_AXES],
	input  logic                                restart,
	output erp_pkg::trig_t                      trig  [erp_pkg::NUM_AXES],
	output logic                                busy
);
	import erp_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RED  = 5'b00010,
		ST_RAD  = 5'b00100,
		ST_ITER = 5'b01000,
		ST_DONE = 5'b10000
	} trig_st_t;

	trig_st_t             state_q;
	logic                 pend_q;
	logic [1:0]           axis_q;
	logic [MAG_W-1:0]     mag_q;
	logic                 neg_q;
	logic                 flip_q;
	logic [ITER_W-1:0]    cnt_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	trig_t                trig_q [NUM_AXES];

	logic signed [17:0]   a0, a1, a2, a3, a4, r;
	logic                 flip_c;
	logic [RAD_P_W-1:0]   rad_p;
	logic [RAD_P_W-1:0]   rad_r;
	logic signed [CW-1:0] z_mag;
	logic signed [CW-1:0] dx, dy, at;
	logic signed [CW-1:0] x_f, y_f;

	// Wrap the angle into one turn, then fold into a quarter turn
	always_comb begin
		a0 = {angle[axis_q][ANGLE_W-1], angle[axis_q]};
		a1 = (a0 > 18'sd18000) ? a0 - 18'sd36000 : a0;
		a2 = (a1 > 18'sd18000) ? a1 - 18'sd36000 : a1;
		a3 = (a2 <= -18'sd18000) ? a2 + 18'sd36000 : a2;
		a4 = (a3 <= -18'sd18000) ? a3 + 18'sd36000 : a3;
		flip_c = 1'b0;
		r = a4;
		if (a4 > 18'sd9000) begin
			r = a4 - 18'sd18000;
			flip_c = 1'b1;
		end else if (a4 < -18'sd9000) begin
			r = a4 + 18'sd18000;
			flip_c = 1'b1;
		end
	end

	// Hundredths of a degree to radians, Q30
	always_comb begin
		rad_p = {{RAD_C_W{1'b0}}, mag_q} * {{MAG_W{1'b0}}, DEG100_TO_RAD_Q40};
		rad_r = rad_p + RAD_P_W'(512);
		z_mag = CW'(rad_r[RAD_P_W-1:10]);
	end

	// One CORDIC micro-rotation
	always_comb begin
		dx  = y_q >>> cnt_q;
		dy  = x_q >>> cnt_q;
		at  = atan_q30(cnt_q);
		x_f = flip_q ? -x_q : x_q;
		y_f = flip_q ? -y_q : y_q;
	end

	// Sequence the three axes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b1;
			axis_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (restart) begin
				pend_q <= 1'b1;
			end else if (state_q == ST_IDLE && pend_q) begin
				pend_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pend_q) begin
						axis_q  <= '0;
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					state_q <= ST_RAD;
				end
				ST_RAD: begin
					cnt_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ITER_W'(NUM_ITER - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (axis_q == 2'(NUM_AXES - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_RED;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RED: begin
				mag_q  <= MAG_W'(r[17] ? -r : r);
				neg_q  <= r[17];
				flip_q <= flip_c;
			end
			ST_RAD: begin
				z_q <= neg_q ? -z_mag : z_mag;
				x_q <= INV_GAIN_Q30;
				y_q <= '0;
			end
			ST_ITER: begin
				if (!z_q[CW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
			end
			ST_DONE: begin
				trig_q[axis_q] <= '{sin_v: y_f[TRIG_W-1:0], cos_v: x_f[TRIG_W-1:0]};
			end
			default: ;
		endcase
	end

	assign trig = trig_q;
	assign busy = pend_q || (state_q != ST_IDLE);

endmodule

@@ rtl/erp_rot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_rot
// Two-stage plane rotation: u' = u*cos - w*sin, w' = u*sin + w*cos.
// Products register in the first stage, rounding and summing in the second.
// ----------------------------------------------------------------------------
module erp_rot (
	input  logic                             clk,
	input  logic                             en_p,
	input  logic                             en_q,
	input  logic signed [erp_pkg::CIW-1:0]   u,
	input  logic signed [erp_pkg::CIW-1:0]   w,
	input  erp_pkg::trig_t                   sc,
	output logic signed [erp_pkg::CIW-1:0]   u_new,
	output logic signed [erp_pkg::CIW-1:0]   w_new
);
	import erp_pkg::*;

	logic signed [TRIG_W-1:0] cos_w, sin_w;
	logic signed [PROD_W-1:0] uc_s1, us_s1, wc_s1, ws_s1;
	logic signed [CIW-1:0]    u_s2, w_s2;

	assign cos_w = sc.cos_v;
	assign sin_w = sc.sin_v;

	// Form the four products
	always_ff @(posedge clk) begin
		if (en_p) begin
			uc_s1 <= u * cos_w;
			us_s1 <= u * sin_w;
			wc_s1 <= w * cos_w;
			ws_s1 <= w * sin_w;
		end
	end

	// Round each product and combine
	always_ff @(posedge clk) begin
		if (en_q) begin
			u_s2 <= CIW'(rnd_q30(uc_s1) - rnd_q30(ws_s1));
			w_s2 <= CIW'(rnd_q30(us_s1) + rnd_q30(wc_s1));
		end
	end

	assign u_new = u_s2;
	assign w_new = w_s2;

endmodule

@@ rtl/erp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_checker
// Port-level checks for the pivot rotation core, bound to the top level.
// ----------------------------------------------------------------------------
module erp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic                       pready,
	input logic [erp_pkg::ADDR_W-1:0] paddr
);
	import erp_pkg::*;

	localparam int DEPTH = 8;

	logic [3:0] occ_q;
	logic       in_acc, out_acc, ang_wr;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign ang_wr  = psel && penable && pwrite &&
		(paddr[4:2] == REG_ANG_X || paddr[4:2] == REG_ANG_Y || paddr[4:2] == REG_ANG_Z);

	// Track words inside the core
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// Never more words in flight than pipeline stages
	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 4'(DEPTH))
		else $error("more words in flight than pipeline stages");

	// A result word needs an accepted point behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occ_q != '0)
		else $error("result word with no point in flight");

	// An angle write blocks input while sine and cosine refresh
	a_ang_block: assert property (@(posedge clk) disable iff (!arst_n)
		ang_wr && pready |=> !in_acc)
		else $error("point accepted right after an angle write");

endmodule

bind euler_rotate_point_about_pivot_core erp_checker u_erp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (point.valid),
	.in_ready  (point.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.pready    (pready),
	.paddr     (paddr)
);

@@ tb/erp_rotation_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_rotation_scoreboard
// Predicts each rotated point from the current angles and pivot and checks
// the core's result words against the predictions in order.
// ----------------------------------------------------------------------------
package erp_rotation_sb_pkg;
	import erp_pkg::*;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      sat;
	} rotated_point_t;

	class erp_rotation_scoreboard;
		longint angle_deg100 [NUM_AXES];
		longint pivot_q16 [NUM_AXES];
		rotated_point_t pending_points[$];
		int mismatches;
		int points_checked;
		int saturated_seen;

		function new();
			foreach (angle_deg100[i]) begin
				angle_deg100[i] = 0;
				pivot_q16[i] = 0;
			end
			mismatches = 0;
			points_checked = 0;
			saturated_seen = 0;
		endfunction

		// Mirror one register write; unknown indexes are ignored
		function void write_reg(int idx, logic [DATA_W-1:0] value);
			logic signed [ANGLE_W-1:0] a;
			logic signed [COORD_W-1:0] p;
			a = value[ANGLE_W-1:0];
			p = value[COORD_W-1:0];
			if (idx >= REG_ANG_X && idx <= REG_ANG_Z)
				angle_deg100[idx] = a;
			else if (idx >= REG_PIV_X && idx <= REG_PIV_Z)
				pivot_q16[idx - REG_PIV_X] = p;
		endfunction

		static function longint shift_floor(longint v, int s);
			return v >>> s;
		endfunction

		// round(a * c / 2^30), half away from zero
		static function longint scale_q30(longint a, longint c);
			logic neg;
			longint unsigned ua, uc, hi, lo, r;
			neg = (a < 0) != (c < 0);
			ua = (a < 0) ? -a : a;
			uc = (c < 0) ? -c : c;
			hi = ua >> 30;
			lo = ua & ((64'd1 << 30) - 1);
			r = hi * uc + ((lo * uc + (64'd1 << 29)) >> 30);
			return neg ? -longint'(r) : longint'(r);
		endfunction

		static function longint arctan_q30(int i);
			longint t [24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
				33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
				262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023,
				511, 255, 127};
			return t[i];
		endfunction

		// Reduce the angle to a quadrant, then run the rotation-mode CORDIC
		static function void sine_cosine(longint ang, output longint s, output longint c);
			longint r, z, x, y, mag, dx, dy;
			logic flip;
			r = ang % 36000;
			flip = 0;
			if (r < 0) r += 36000;
			if (r > 18000) r -= 36000;
			if (r > 9000) begin
				r -= 18000;
				flip = 1;
			end else if (r < -9000) begin
				r += 18000;
				flip = 1;
			end
			mag = (r < 0) ? -r : r;
			z = (mag * 191900981 + 512) >>> 10;
			if (r < 0) z = -z;
			x = 652032874;
			y = 0;
			for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
				dx = shift_floor(y, i);
				dy = shift_floor(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= arctan_q30(i);
				end else begin
					x += dx; y -= dy; z += arctan_q30(i);
				end
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			s = y;
			c = x;
		endfunction

		static function longint clamp_coord(longint v, ref logic sat);
			longint hi, lo;
			hi = (longint'(1) <<< (COORD_W - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) begin
				sat = 1;
				return hi;
			end
			if (v < lo) begin
				sat = 1;
				return lo;
			end
			return v;
		endfunction

		// Note an accepted point and queue its expected rotation
		function void note_point(logic signed [COORD_W-1:0] px,
				logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz);
			longint m, n, o, s, c, a, b;
			logic sat;
			rotated_point_t e;
			m = longint'(px) - pivot_q16[0];
			n = longint'(py) - pivot_q16[1];
			o = longint'(pz) - pivot_q16[2];
			sat = 0;
			sine_cosine(angle_deg100[0], s, c);
			a = scale_q30(n, c) - scale_q30(o, s);
			b = scale_q30(n, s) + scale_q30(o, c);
			n = a; o = b;
			sine_cosine(angle_deg100[1], s, c);
			a = scale_q30(o, s) + scale_q30(m, c);
			b = scale_q30(o, c) - scale_q30(m, s);
			m = a; o = b;
			sine_cosine(angle_deg100[2], s, c);
			a = scale_q30(m, c) - scale_q30(n, s);
			b = scale_q30(m, s) + scale_q30(n, c);
			m = a; n = b;
			e.x = COORD_W'(clamp_coord(m + pivot_q16[0], sat));
			e.y = COORD_W'(clamp_coord(n + pivot_q16[1], sat));
			e.z = COORD_W'(clamp_coord(o + pivot_q16[2], sat));
			e.sat = sat;
			pending_points.push_back(e);
		endfunction

		// Compare one result word with the oldest expectation
		function void check_result(rotated_point_t got);
			rotated_point_t e;
			if (pending_points.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result x=%0d y=%0d z=%0d sat=%0b",
					$time, got.x, got.y, got.z, got.sat);
				return;
			end
			e = pending_points.pop_front();
			points_checked++;
			if (got.sat) saturated_seen++;
			if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.sat !== e.sat) begin
				mismatches++;
				$display("%0t: mismatch expected x=%0d y=%0d z=%0d sat=%0b", $time,
					e.x, e.y, e.z, e.sat);
				$display("%0t:          actual   x=%0d y=%0d z=%0d sat=%0b", $time,
					got.x, got.y, got.z, got.sat);
			end
		endfunction
	endclass
endpackage

@@ tb/euler_rotate_point_about_pivot_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_rotate_point_about_pivot_core_tb
// Streams directed and random points through the core under several angle
// and pivot settings, with random idling and a long result-side hold-off,
// and checks every rotated point against an in-bench predictor.
// ----------------------------------------------------------------------------
module euler_rotate_point_about_pivot_core_tb;
	import erp_pkg::*;
	import erp_rotation_sb_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	erp_point_if point ();
	erp_result_if result ();

	euler_rotate_point_about_pivot_core dut (
		.clk(clk), .arst_n(arst_n), .point(point.sink), .result(result.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	erp_rotation_scoreboard rotation_sb = new();
	int idle_pct_in = 17, idle_pct_out = 17;
	logic hold_results = 0;
	int stall_cycles;
	int sent_points = 0;

	always #5 clk = ~clk;

	initial begin
		point.valid = 0;
		point.point_x = '0;
		point.point_y = '0;
		point.point_z = '0;
		result.ready = 0;
	end

	// Result side: random idling, optional long hold-off
	always @(negedge clk) begin
		if (hold_results)
			result.ready <= 0;
		else
			result.ready <= ($urandom_range(99) >= idle_pct_out);
	end

	// Check each accepted result word
	always @(posedge clk) begin
		rotated_point_t got;
		if (arst_n && result.valid && result.ready) begin
			got.x = result.rotated_x;
			got.y = result.rotated_y;
			got.z = result.rotated_z;
			got.sat = result.saturated;
			rotation_sb.check_result(got);
		end
	end

	// Watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((point.valid && point.ready) || (result.valid && result.ready) || !arst_n
				|| psel)
			stall_cycles = 0;
		else if (++stall_cycles >= WATCHDOG_LIMIT) begin
			$display("euler_rotate_point_about_pivot_core test failed");
			$finish;
		end
	end

	// Register write: setup phase, then access phase until pready
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		rotation_sb.write_reg(idx, value);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// Offer one point and hold it until accepted
	task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z);
		while ($urandom_range(99) < idle_pct_in) begin
			point.valid <= 0;
			@(negedge clk);
		end
		point.valid <= 1;
		point.point_x <= x;
		point.point_y <= y;
		point.point_z <= z;
		do @(posedge clk); while (!point.ready);
		rotation_sb.note_point(x, y, z);
		sent_points++;
		@(negedge clk);
	endtask

	task automatic drain();
		point.valid <= 0;
		while (rotation_sb.pending_points.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_angles(int ax, int ay, int az);
		write_reg(REG_ANG_X, DATA_W'(ax));
		write_reg(REG_ANG_Y, DATA_W'(ay));
		write_reg(REG_ANG_Z, DATA_W'(az));
	endtask

	task automatic set_pivot(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		write_reg(REG_PIV_X, x);
		write_reg(REG_PIV_Y, y);
		write_reg(REG_PIV_Z, z);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(3);
			1: return 32'h7FFF_FFFF - $urandom_range(3);
			2: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_angle();
		case ($urandom_range(5))
			0: return 36000;
			1: return -36000;
			2: return 9000 * ($signed($urandom_range(8)) - 4);
			3: return -65536 + $urandom_range(131071);
			default: return $signed($urandom_range(72000)) - 36000;
		endcase
	endfunction

	initial begin
		int angle_set [6][3] = '{'{0, 0, 0}, '{36000, -36000, 18000},
			'{9000, -9000, 27000}, '{-17999, 18001, 4500}, '{65535, -65536, 1},
			'{3000, 4500, -6000}};
		repeat (5) @(negedge clk);
		arst_n = 1;

		// Directed: extremes of the points under a few settings
		for (int k = 0; k < 3; k++) begin
			if (k > 0) begin
				drain();
				set_angles(angle_set[k][0], angle_set[k][1], angle_set[k][2]);
				set_pivot(k == 1 ? 32'h7FFF_FFFF : 32'h8000_0000, 32'h0001_0000,
					k == 1 ? 32'h8000_0000 : 32'h7FFF_FFFF);
			end
			send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
			send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
			send_point(32'h0, 32'h0, 32'h0);
			send_point(32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA);
			send_point(32'hAAAA_5555, 32'h0000_8000, 32'h7FFF_FFFF);
		end

		// Random phases, one of them with a long result hold-off
		for (int ph = 0; ph < 12; ph++) begin
			drain();
			if (ph < 3)
				set_angles(angle_set[ph + 3][0], angle_set[ph + 3][1],
					angle_set[ph + 3][2]);
			else
				set_angles(rand_angle(), rand_angle(), rand_angle());
			if (ph % 3 == 0)
				set_pivot(0, 0, 0);
			else
				set_pivot(rand_coord(), rand_coord(), rand_coord());
			idle_pct_in = (ph == 5) ? 0 : 17;
			idle_pct_out = (ph == 5) ? 0 : 17;
			if (ph == 7) begin
				fork
					begin
						hold_results = 1;
						repeat (200) @(negedge clk);
						hold_results = 0;
					end
				join_none
			end
			for (int i = 0; i < 100; i++)
				send_point(rand_coord(), rand_coord(), rand_coord());
		end
		drain();

		$display("Sent %0d points over 15 angle/pivot settings; %0d results checked, %0d saturated.",
			sent_points, rotation_sb.points_checked, rotation_sb.saturated_seen);
		if (rotation_sb.mismatches == 0)
			$display("euler_rotate_point_about_pivot_core test passed");
		else
			$display("euler_rotate_point_about_pivot_core test failed");
		$finish;
	end
endmodule
